[sv/adsr_pkg.sv]
// Shared types and constants for the ADSR envelope generator.
package adsr_pkg;

  localparam int TIME_W  = 32;               // sample tick width
  localparam int LEVEL_W = 16;               // Q1.15 level width
  localparam int DUR_W   = 24;               // duration register width
  localparam int PROD_W  = DUR_W + LEVEL_W;  // multiplier product width
  localparam int CNT_W   = $clog2(LEVEL_W);  // divider step counter
  localparam int IDX_W   = 3;                // config register index width

  localparam logic [1:0] ACT_QUERY = 2'd0;
  localparam logic [1:0] ACT_ON    = 2'd1;
  localparam logic [1:0] ACT_OFF   = 2'd2;

  localparam logic [IDX_W-1:0] REG_ATTACK  = 3'd0;
  localparam logic [IDX_W-1:0] REG_DECAY   = 3'd1;
  localparam logic [IDX_W-1:0] REG_RELEASE = 3'd2;
  localparam logic [IDX_W-1:0] REG_PEAK    = 3'd3;
  localparam logic [IDX_W-1:0] REG_HOLD    = 3'd4;
  localparam logic [IDX_W-1:0] REG_FLOOR   = 3'd5;

  typedef enum logic [2:0] {
    S_IDLE,
    S_CURVE,
    S_CDIV,
    S_REL,
    S_RDIV,
    S_DONE
  } state_t;

  typedef struct packed {
    logic              start;
    logic [PROD_W-1:0] dividend;
    logic [DUR_W-1:0]  divisor;
  } div_req_t;

  typedef struct packed {
    logic               busy;
    logic               done;
    logic [LEVEL_W-1:0] quot;
  } div_rsp_t;

endpackage

[sv/adsr_envelope_generator_top.sv]
// Top level of the linear ADSR envelope generator.
//
//   channel | ports                                  | handshake
//   --------+----------------------------------------+----------------
//   input   | in_action[1:0], in_sample_time[31:0]   | in_valid/in_stall
//   result  | out_amplitude[15:0]                    | out_valid/out_stall
//   config  | cfg_index[2:0], cfg_data[23:0]         | cfg_valid/cfg_ready
//
// Note-on and note-off are taken without stalling the input and give no result.
// A query whose level is known at once goes straight to S_DONE; S_CURVE gives the sustain level
// directly, else one pass of the shared 24x16 multiplier and 16-step divider, and a release adds a second pass.
// in_stall is high while a query is in progress; the result waits in an output register.
// Synchronous active-low reset restores register defaults and clears the gate.
module adsr_envelope_generator_top (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        in_valid,
  output logic        in_stall,
  input  logic [1:0]  in_action,
  input  logic [31:0] in_sample_time,
  output logic        out_valid,
  input  logic        out_stall,
  output logic [15:0] out_amplitude,
  input  logic        cfg_valid,
  output logic        cfg_ready,
  input  logic [2:0]  cfg_index,
  input  logic [23:0] cfg_data
);

  localparam int TW = adsr_pkg::TIME_W;
  localparam int LW = adsr_pkg::LEVEL_W;
  localparam int DW = adsr_pkg::DUR_W;

  // Configuration registers
  logic [DW-1:0] attack_r, decay_r, release_r;
  logic [LW-1:0] peak_r, hold_r, floor_r;

  // Note state
  logic          gate_r, gate_nxt;
  logic [TW-1:0] on_r, on_nxt;
  logic [TW-1:0] off_r, off_nxt;

  // Query working registers
  adsr_pkg::state_t state_r, state_nxt;
  logic [TW-1:0] life_r, life_nxt;
  logic [DW-1:0] rmul_r, rmul_nxt;
  logic [LW-1:0] level_r, level_nxt;
  logic          rel_r, rel_nxt;
  logic          decay_sel_r, decay_sel_nxt;
  logic          out_valid_r, out_valid_nxt;
  logic [LW-1:0] out_amp_r, out_amp_nxt;

  // Shared arithmetic
  logic [DW-1:0]          mul_a;
  logic [LW-1:0]          mul_b;
  logic [DW-1:0]          div_den;
  logic                   div_go;
  adsr_pkg::div_req_t     div_req;
  adsr_pkg::div_rsp_t     div_rsp;

  // Derived values
  logic [DW-1:0] a_nz, d_nz, r_nz;
  logic [DW:0]   ad_sum;
  logic          up;
  logic [LW-1:0] lvl_diff;
  logic [TW-1:0] t_on, t_off, off_on;
  logic          accept, out_free;

  assign accept   = in_valid && !in_stall;
  assign out_free = !out_valid_r || !out_stall;

  assign a_nz     = (attack_r == '0) ? DW'(1) : attack_r;
  assign d_nz     = (decay_r == '0) ? DW'(1) : decay_r;
  assign r_nz     = (release_r == '0) ? DW'(1) : release_r;
  assign ad_sum   = {1'b0, a_nz} + {1'b0, d_nz};
  assign up       = hold_r >= peak_r;
  assign lvl_diff = up ? (hold_r - peak_r) : (peak_r - hold_r);
  assign t_on     = in_sample_time - on_r;
  assign t_off    = in_sample_time - off_r;
  assign off_on   = off_r - on_r;

  assign div_req.start    = div_go;
  assign div_req.dividend = mul_a * mul_b;
  assign div_req.divisor  = div_den;

  adsr_div u_div (
    .clk   (clk),
    .rst_n (rst_n),
    .req   (div_req),
    .rsp   (div_rsp)
  );

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      attack_r  <= DW'(480);
      decay_r   <= DW'(480);
      release_r <= DW'(48000);
      peak_r    <= LW'(32768);
      hold_r    <= LW'(32768);
      floor_r   <= LW'(3277);
    end else if (cfg_valid && cfg_ready) begin
      case (cfg_index)
        adsr_pkg::REG_ATTACK:  attack_r  <= cfg_data;
        adsr_pkg::REG_DECAY:   decay_r   <= cfg_data;
        adsr_pkg::REG_RELEASE: release_r <= cfg_data;
        adsr_pkg::REG_PEAK:    peak_r    <= cfg_data[LW-1:0];
        adsr_pkg::REG_HOLD:    hold_r    <= cfg_data[LW-1:0];
        adsr_pkg::REG_FLOOR:   floor_r   <= cfg_data[LW-1:0];
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= adsr_pkg::S_IDLE;
      gate_r      <= 1'b0;
      on_r        <= '0;
      off_r       <= '0;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      gate_r      <= gate_nxt;
      on_r        <= on_nxt;
      off_r       <= off_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    life_r      <= life_nxt;
    rmul_r      <= rmul_nxt;
    level_r     <= level_nxt;
    rel_r       <= rel_nxt;
    decay_sel_r <= decay_sel_nxt;
    out_amp_r   <= out_amp_nxt;
  end

  always_comb begin
    state_nxt     = state_r;
    gate_nxt      = gate_r;
    on_nxt        = on_r;
    off_nxt       = off_r;
    life_nxt      = life_r;
    rmul_nxt      = rmul_r;
    level_nxt     = level_r;
    rel_nxt       = rel_r;
    decay_sel_nxt = decay_sel_r;
    out_valid_nxt = out_valid_r && out_stall;
    out_amp_nxt   = out_amp_r;
    mul_a         = rmul_r;
    mul_b         = level_r;
    div_den       = r_nz;
    div_go        = 1'b0;

    case (state_r)
      adsr_pkg::S_IDLE: begin
        if (accept) begin
          case (in_action)
            adsr_pkg::ACT_ON: begin
              on_nxt   = in_sample_time;
              gate_nxt = 1'b1;
            end
            adsr_pkg::ACT_OFF: begin
              off_nxt  = in_sample_time;
              gate_nxt = 1'b0;
            end
            adsr_pkg::ACT_QUERY: begin
              level_nxt = '0;
              rel_nxt   = 1'b0;
              life_nxt  = t_on;
              rmul_nxt  = r_nz - t_off[DW-1:0];
              if (gate_r) begin
                state_nxt = (in_sample_time >= on_r) ? adsr_pkg::S_CURVE : adsr_pkg::S_DONE;
              end else if (in_sample_time < off_r || t_off >= TW'(r_nz) || off_r < on_r) begin
                state_nxt = adsr_pkg::S_DONE;
              end else begin
                // Release: curve level at note-off, then scale it down
                life_nxt  = off_on;
                rel_nxt   = 1'b1;
                state_nxt = adsr_pkg::S_CURVE;
              end
            end
            default: ;
          endcase
        end
      end

      adsr_pkg::S_CURVE: begin
        if (life_r <= TW'(a_nz)) begin
          mul_a         = life_r[DW-1:0];
          mul_b         = peak_r;
          div_den       = a_nz;
          div_go        = 1'b1;
          decay_sel_nxt = 1'b0;
          state_nxt     = adsr_pkg::S_CDIV;
        end else if (life_r <= TW'(ad_sum)) begin
          mul_a         = life_r[DW-1:0] - a_nz;
          mul_b         = lvl_diff;
          div_den       = d_nz;
          div_go        = 1'b1;
          decay_sel_nxt = 1'b1;
          state_nxt     = adsr_pkg::S_CDIV;
        end else begin
          level_nxt = hold_r;
          state_nxt = rel_r ? adsr_pkg::S_REL : adsr_pkg::S_DONE;
        end
      end

      adsr_pkg::S_CDIV: begin
        if (div_rsp.done) begin
          if (!decay_sel_r) begin
            level_nxt = div_rsp.quot;
          end else if (up) begin
            level_nxt = peak_r + div_rsp.quot;
          end else begin
            level_nxt = peak_r - div_rsp.quot;
          end
          state_nxt = rel_r ? adsr_pkg::S_REL : adsr_pkg::S_DONE;
        end
      end

      adsr_pkg::S_REL: begin
        div_go    = 1'b1;
        state_nxt = adsr_pkg::S_RDIV;
      end

      adsr_pkg::S_RDIV: begin
        if (div_rsp.done) begin
          level_nxt = div_rsp.quot;
          state_nxt = adsr_pkg::S_DONE;
        end
      end

      adsr_pkg::S_DONE: begin
        // Hold until the output register is free
        if (out_free) begin
          out_valid_nxt = 1'b1;
          out_amp_nxt   = (level_r <= floor_r) ? '0 : level_r;
          state_nxt     = adsr_pkg::S_IDLE;
        end
      end

      default: state_nxt = adsr_pkg::S_IDLE;
    endcase
  end

  assign in_stall      = state_r != adsr_pkg::S_IDLE;
  assign out_valid     = out_valid_r;
  assign out_amplitude = out_amp_r;
  assign cfg_ready     = 1'b1;

  a_query_busy: assert property (@(posedge clk) disable iff (!rst_n)
    accept && in_action == adsr_pkg::ACT_QUERY |=> in_stall)
    else $error("query did not occupy the block");

  a_note_quick: assert property (@(posedge clk) disable iff (!rst_n)
    accept && (in_action == adsr_pkg::ACT_ON || in_action == adsr_pkg::ACT_OFF)
    |=> !in_stall)
    else $error("note event stalled the input");

  a_div_idle: assert property (@(posedge clk) disable iff (!rst_n)
    div_req.start |-> !div_rsp.busy)
    else $error("divider restarted while busy");

  a_result_out: assert property (@(posedge clk) disable iff (!rst_n)
    state_r == adsr_pkg::S_DONE && out_free |=> out_valid && !in_stall)
    else $error("finished query did not reach the output");

endmodule

[sv/adsr_div.sv]
// Radix-2 restoring divider; quotient known to fit LEVEL_W bits.
module adsr_div (
  input  logic              clk,
  input  logic              rst_n,
  input  adsr_pkg::div_req_t req,
  output adsr_pkg::div_rsp_t rsp
);

  logic                          busy_r;
  logic                          done_r;
  logic [adsr_pkg::CNT_W-1:0]    cnt_r;
  logic [adsr_pkg::DUR_W-1:0]    rem_r;
  logic [adsr_pkg::DUR_W-1:0]    den_r;
  logic [adsr_pkg::LEVEL_W-1:0]  quo_r;

  logic [adsr_pkg::DUR_W:0]      trial;
  logic [adsr_pkg::DUR_W:0]      sub;
  logic                          ge;

  // Shift in the next dividend bit and try the subtraction
  assign trial = {rem_r, quo_r[adsr_pkg::LEVEL_W-1]};
  assign sub   = trial - {1'b0, den_r};
  assign ge    = trial >= {1'b0, den_r};

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= 1'b0;
      done_r <= 1'b0;
      cnt_r  <= '0;
    end else if (req.start) begin
      busy_r <= 1'b1;
      done_r <= 1'b0;
      cnt_r  <= '0;
    end else if (busy_r) begin
      if (cnt_r == adsr_pkg::CNT_W'(adsr_pkg::LEVEL_W - 1)) begin
        busy_r <= 1'b0;
        done_r <= 1'b1;
      end
      cnt_r <= cnt_r + 1'b1;
    end else begin
      done_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (req.start) begin
      // Upper bits are below the divisor, so only LEVEL_W steps remain
      rem_r <= req.dividend[adsr_pkg::PROD_W-1:adsr_pkg::LEVEL_W];
      quo_r <= req.dividend[adsr_pkg::LEVEL_W-1:0];
      den_r <= req.divisor;
    end else if (busy_r) begin
      rem_r <= ge ? sub[adsr_pkg::DUR_W-1:0] : trial[adsr_pkg::DUR_W-1:0];
      quo_r <= {quo_r[adsr_pkg::LEVEL_W-2:0], ge};
    end
  end

  assign rsp.busy = busy_r;
  assign rsp.done = done_r;
  assign rsp.quot = quo_r;

endmodule

[verif/adsr_envelope_generator_tb.sv]
`timescale 1ns / 100ps
// Self-checking bench for the ADSR envelope generator: directed notes, then random notes per setting.
module tb;

  localparam logic [1:0] ACT_NONE = 2'd3;
  localparam logic [adsr_pkg::IDX_W-1:0] REG_SPARE_LO = 3'd6;
  localparam logic [adsr_pkg::IDX_W-1:0] REG_SPARE_HI = 3'd7;
  localparam int PHASE_REQS = 225;
  localparam int SETTLE_CYCLES = 60;

  typedef struct packed {
    logic [1:0]  action;
    logic [31:0] tick;
  } env_req_t;

  typedef struct packed {
    logic [23:0] attack_ticks;
    logic [23:0] decay_ticks;
    logic [23:0] release_ticks;
    logic [15:0] peak_level;
    logic [15:0] hold_level;
    logic [15:0] floor_level;
  } env_cfg_t;

  logic        clk            = 1'b0;
  logic        rst_n          = 1'b0;
  logic        in_valid       = 1'b0;
  logic        in_stall;
  logic [1:0]  in_action      = adsr_pkg::ACT_QUERY;
  logic [31:0] in_sample_time = '0;
  logic        out_valid;
  logic        out_stall      = 1'b0;
  logic [15:0] out_amplitude;
  logic        cfg_valid      = 1'b0;
  logic        cfg_ready;
  logic [2:0]  cfg_index      = '0;
  logic [23:0] cfg_data       = '0;

  // bench controls
  logic quiet        = 1'b0;
  logic sender_pause = 1'b0;

  env_req_t    pending [$];
  env_req_t    next_req;
  logic [15:0] amp_expected [$];
  logic [15:0] want;
  int unsigned fails          = 0;
  int unsigned results_seen   = 0;
  int unsigned hold_left      = 0;
  bit          long_hold_done = 1'b0;

  // predictor state
  env_cfg_t    cfg_m     = '{24'd480, 24'd480, 24'd48000, 16'd32768, 16'd32768, 16'd3277};
  logic        gate_open = 1'b0;
  logic [31:0] last_on   = '0;
  logic [31:0] last_off  = '0;

  adsr_envelope_generator_top i_dut (
    .clk            (clk),
    .rst_n          (rst_n),
    .in_valid       (in_valid),
    .in_stall       (in_stall),
    .in_action      (in_action),
    .in_sample_time (in_sample_time),
    .out_valid      (out_valid),
    .out_stall      (out_stall),
    .out_amplitude  (out_amplitude),
    .cfg_valid      (cfg_valid),
    .cfg_ready      (cfg_ready),
    .cfg_index      (cfg_index),
    .cfg_data       (cfg_data)
  );

  always #5 clk = ~clk;

  function automatic logic [63:0] ticks_or_one(logic [63:0] v);
    return (v == 0) ? 64'd1 : v;
  endfunction

  function automatic logic [63:0] curve_at(logic [63:0] life);
    logic [63:0] a, d, gap, step;
    a = ticks_or_one(cfg_m.attack_ticks);
    d = ticks_or_one(cfg_m.decay_ticks);
    if (life <= a) return life * cfg_m.peak_level / a;
    if (life <= a + d) begin
      gap = (cfg_m.hold_level >= cfg_m.peak_level) ? cfg_m.hold_level - cfg_m.peak_level
                                                    : cfg_m.peak_level - cfg_m.hold_level;
      step = gap * (life - a) / d;
      return (cfg_m.hold_level >= cfg_m.peak_level) ? cfg_m.peak_level + step
                                                    : cfg_m.peak_level - step;
    end
    return cfg_m.hold_level;
  endfunction

  function automatic logic [15:0] amp_at(logic [31:0] t);
    logic [63:0] lvl, r, e, held;
    lvl = 0;
    if (gate_open) begin
      if (t >= last_on) lvl = curve_at(t - last_on);
    end else if (t >= last_off) begin
      r = ticks_or_one(cfg_m.release_ticks);
      e = t - last_off;
      held = (last_off >= last_on) ? curve_at(last_off - last_on) : 64'd0;
      if (e < r) lvl = held * (r - e) / r;
    end
    if (lvl <= cfg_m.floor_level) lvl = 0;
    if (lvl > 64'hFFFF) lvl = 64'hFFFF;
    return lvl[15:0];
  endfunction

  function automatic int add_req(logic [1:0] act, logic [31:0] tick);
    env_req_t r;
    r.action = act;
    r.tick = tick;
    pending.push_back(r);
    return (act == ACT_NONE) ? 0 : 1;
  endfunction

  // One note: on, queries over attack/decay/sustain, off, queries over release.
  function automatic int queue_note(env_cfg_t c);
    logic [31:0] on_t, off_t, span, rspan;
    int made;
    made = 0;
    on_t = $urandom;
    span = 32'(ticks_or_one(c.attack_ticks) + ticks_or_one(c.decay_ticks)) + 32'd8;
    rspan = 32'(ticks_or_one(c.release_ticks)) + 32'd4;
    made += add_req(adsr_pkg::ACT_ON, on_t);
    repeat ($urandom_range(1, 5))
      made += add_req(adsr_pkg::ACT_QUERY, on_t + $urandom_range(0, span + span / 4));
    if ($urandom_range(0, 9) == 0)
      made += add_req(adsr_pkg::ACT_QUERY, on_t - $urandom_range(1, span));
    off_t = on_t + $urandom_range(0, span + span / 2);
    made += add_req(adsr_pkg::ACT_OFF, off_t);
    repeat ($urandom_range(1, 5))
      made += add_req(adsr_pkg::ACT_QUERY, off_t + $urandom_range(0, rspan + rspan / 8));
    if ($urandom_range(0, 9) == 0)
      made += add_req(adsr_pkg::ACT_QUERY, off_t - $urandom_range(1, 100));
    return made;
  endfunction

  function automatic int queue_noise();
    int made;
    made = 0;
    repeat ($urandom_range(1, 4)) made += add_req(2'($urandom_range(0, 3)), $urandom);
    return made;
  endfunction

  task automatic drain();
    while (pending.size() != 0 || in_valid || amp_expected.size() != 0) @(posedge clk);
    // note-on and note-off leave nothing to wait for; let the block settle
    repeat (SETTLE_CYCLES) @(posedge clk);
  endtask

  task automatic load_settings(env_cfg_t c, bit poke_spare);
    logic [2:0]  idx [8];
    logic [23:0] val [8];
    int k;
    idx = '{REG_SPARE_LO, REG_SPARE_HI, adsr_pkg::REG_ATTACK, adsr_pkg::REG_DECAY,
            adsr_pkg::REG_RELEASE, adsr_pkg::REG_PEAK, adsr_pkg::REG_HOLD,
            adsr_pkg::REG_FLOOR};
    val = '{24'($urandom), 24'($urandom), c.attack_ticks, c.decay_ticks, c.release_ticks,
            {8'($urandom), c.peak_level}, {8'($urandom), c.hold_level},
            {8'($urandom), c.floor_level}};
    for (k = poke_spare ? 0 : 2; k < 8; k++) begin
      cfg_valid <= 1'b1;
      cfg_index <= idx[k];
      cfg_data  <= val[k];
      do @(posedge clk); while (!cfg_ready);
      case (idx[k])
        adsr_pkg::REG_ATTACK:  cfg_m.attack_ticks  = val[k];
        adsr_pkg::REG_DECAY:   cfg_m.decay_ticks   = val[k];
        adsr_pkg::REG_RELEASE: cfg_m.release_ticks = val[k];
        adsr_pkg::REG_PEAK:    cfg_m.peak_level    = val[k][15:0];
        adsr_pkg::REG_HOLD:    cfg_m.hold_level    = val[k][15:0];
        adsr_pkg::REG_FLOOR:   cfg_m.floor_level   = val[k][15:0];
        default: ;
      endcase
    end
    cfg_valid <= 1'b0;
  endtask

  // request driver
  always @(posedge clk) begin
    if (!rst_n) begin
      in_valid <= 1'b0;
    end else if (!in_valid || !in_stall) begin
      if (pending.size() != 0 && !sender_pause && (quiet || $urandom_range(0, 99) >= 33)) begin
        next_req = pending.pop_front();
        in_valid       <= 1'b1;
        in_action      <= next_req.action;
        in_sample_time <= next_req.tick;
      end else begin
        in_valid <= 1'b0;
      end
    end
  end

  // track accepted requests and predict query results
  always @(posedge clk) begin
    if (rst_n && in_valid && !in_stall) begin
      case (in_action)
        adsr_pkg::ACT_ON: begin
          gate_open = 1'b1;
          last_on = in_sample_time;
        end
        adsr_pkg::ACT_OFF: begin
          gate_open = 1'b0;
          last_off = in_sample_time;
        end
        adsr_pkg::ACT_QUERY: amp_expected.push_back(amp_at(in_sample_time));
        default: ;
      endcase
    end
  end

  // hold off once for a long stretch so the block backs up into its input
  always @(posedge clk) begin
    if (rst_n && !long_hold_done && results_seen >= 300) begin
      long_hold_done <= 1'b1;
      hold_left      <= 400;
    end else if (hold_left != 0) begin
      hold_left <= hold_left - 1;
    end
  end

  // result monitor and receiver stalls
  always @(posedge clk) begin
    if (!rst_n) begin
      out_stall <= 1'b0;
    end else begin
      if (out_valid && !out_stall) begin
        results_seen++;
        if (amp_expected.size() == 0) begin
          $error("out_amplitude %0d arrived with no query pending", out_amplitude);
          fails++;
        end else begin
          want = amp_expected.pop_front();
          if (out_amplitude !== want) begin
            $error("out_amplitude mismatch: expected %0d, actual %0d", want, out_amplitude);
            fails++;
          end
        end
      end
      out_stall <= (hold_left != 0) || (!quiet && $urandom_range(0, 99) < 33);
    end
  end

  initial begin : stimulus
    env_cfg_t plan [$];
    int made, p;
    plan.push_back('{24'd1, 24'd1, 24'd1, 16'hFFFF, 16'd0, 16'd0});
    plan.push_back('{24'd0, 24'd0, 24'd0, 16'd32768, 16'd16384, 16'd100});
    plan.push_back('{24'($urandom_range(1, 64)), 24'($urandom_range(1, 64)),
                     24'($urandom_range(1, 512)), 16'($urandom), 16'($urandom),
                     16'($urandom_range(0, 1000))});
    plan.push_back('{24'd100, 24'd200, 24'd300, 16'd1000, 16'd60000, 16'd500});
    plan.push_back('{24'hFFFFFF, 24'hFFFFFF, 24'hFFFFFF, 16'hFFFF, 16'hFFFF, 16'hFFFF});
    plan.push_back('{24'($urandom_range(1, 24'hFFFFFF)), 24'($urandom_range(1, 24'hFFFFFF)),
                     24'($urandom_range(1, 24'hFFFFFF)), 16'($urandom), 16'($urandom),
                     16'($urandom_range(0, 4000))});
    plan.push_back('{24'd480, 24'd480, 24'd48000, 16'd32768, 16'd32768, 16'd3277});
    plan.push_back('{24'($urandom_range(1, 32)), 24'($urandom_range(1, 32)),
                     24'($urandom_range(1, 128)), 16'($urandom), 16'($urandom), 16'd0});

    repeat (2) @(posedge clk);
    rst_n <= 1'b1;

    // reset settings: query after reset, off with no on, edges of each segment,
    // floor, past release, off before on, extreme ticks, unknown action
    pending = '{
      '{adsr_pkg::ACT_QUERY, 32'd0},     '{adsr_pkg::ACT_OFF, 32'd100},
      '{adsr_pkg::ACT_QUERY, 32'd100},   '{adsr_pkg::ACT_QUERY, 32'd99},
      '{adsr_pkg::ACT_ON, 32'd1000},     '{adsr_pkg::ACT_QUERY, 32'd999},
      '{adsr_pkg::ACT_QUERY, 32'd1000},  '{adsr_pkg::ACT_QUERY, 32'd1048},
      '{adsr_pkg::ACT_QUERY, 32'd1049},  '{adsr_pkg::ACT_QUERY, 32'd1240},
      '{adsr_pkg::ACT_QUERY, 32'd1480},  '{adsr_pkg::ACT_QUERY, 32'd1720},
      '{adsr_pkg::ACT_QUERY, 32'hFFFFFFFF}, '{ACT_NONE, 32'd5},
      '{adsr_pkg::ACT_OFF, 32'd1240},    '{adsr_pkg::ACT_QUERY, 32'd1239},
      '{adsr_pkg::ACT_QUERY, 32'd25240}, '{adsr_pkg::ACT_QUERY, 32'd49239},
      '{adsr_pkg::ACT_QUERY, 32'd49240}, '{adsr_pkg::ACT_ON, 32'hFFFFFFFF},
      '{adsr_pkg::ACT_QUERY, 32'd0},     '{adsr_pkg::ACT_OFF, 32'd5000},
      '{adsr_pkg::ACT_QUERY, 32'd5000},  '{adsr_pkg::ACT_ON, 32'd0},
      '{adsr_pkg::ACT_OFF, 32'hFFFFFFFF}, '{adsr_pkg::ACT_QUERY, 32'hFFFFFFFF}};

    for (p = 0; p < plan.size(); p++) begin
      drain();
      load_settings(plan[p], p == 1);
      quiet <= (p == 3);
      made = 0;
      while (made < PHASE_REQS) begin
        if ($urandom_range(0, 4) == 0) made += queue_noise();
        else made += queue_note(plan[p]);
      end
      if (p == 5) begin
        // once half the requests are sent, hold the sender until every result is back
        while (pending.size() > made / 2) @(posedge clk);
        sender_pause <= 1'b1;
        @(posedge clk);
        while (in_valid || amp_expected.size() != 0) @(posedge clk);
        sender_pause <= 1'b0;
      end
    end

    drain();
    if (fails == 0) begin
      $display("TB_OK");
    end else begin
      $display("TB_ERROR");
    end
    $finish;
  end

  initial begin : watchdog
    #10_000_000;
    $display("TB_ERROR");
    $finish;
  end

endmodule
